### src/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types, constants and the CRC-8 bit network for the block framer.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Data bytes in one group; one check byte closes each group
  localparam int GroupDataBytes = 5;
  localparam int PosW           = 3;
  localparam logic [PosW-1:0] GroupEnd = PosW'(GroupDataBytes);

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Register file
  localparam int AddrW = 4;
  localparam int DataW = 32;
  localparam logic [7:0] PolyRst   = 8'h07;
  localparam logic [7:0] InitRst   = 8'h00;
  localparam logic [7:0] XorOutRst = 8'h00;

  typedef enum logic [1:0] {
    REG_POLY    = 2'd0,
    REG_INIT    = 2'd1,
    REG_XOR_OUT = 2'd2
  } reg_e;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Work kinds handed from front to back
  typedef enum logic [2:0] {
    OP_ENC_DATA,   // data byte only
    OP_ENC_CHECK,  // data byte, then check byte
    OP_ENC_PAD,    // data byte, zero pads, then check byte
    OP_DEC_DATA,   // decoded data byte
    OP_DEC_CHECK   // received check byte
  } op_e;

  // Back-end sequencer phases
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_PAD,
    PH_CRC
  } phase_e;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] init;
    logic [7:0] xor_out;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic [7:0]      data;
    logic [7:0]      crc;     // running CRC after this byte
    logic [PosW-1:0] pos;     // group position after this byte
    logic [1:0]      status;
  } entry_t;

  // One byte through the MSB-first CRC-8 shift network
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] r;
    r = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### src/crc8_block_framer.sv
// ----------------------------------------------------------------------------
// crc8_block_framer
// CRC-8 block framer: five data bytes per group, one check byte per group.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while its four-entry work queue has room (full
// low); the front end runs the one-byte CRC update combinationally. A
// byte's first result reaches the result ports via the work queue and a
// single output register, and results leave at one per cycle while pop
// drains them: an encoded group of five bytes gives six results, a short
// final group one more per zero pad byte plus one for the check byte, with
// padded CRC steps done by the back end one byte per cycle. Configuration
// must be written only while the block is idle, a rule the user enforces.
module crc8_block_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input queue
  input  logic                      push,
  output logic                      full,
  input  logic                      action_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  // result queue
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_byte_o,
  output logic                      is_check_o,
  output logic [1:0]                status_o,
  output logic                      end_of_run_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cbf_pkg::AddrW-1:0] paddr,
  input  logic [cbf_pkg::DataW-1:0] pwdata,
  output logic [cbf_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import cbf_pkg::*;

  cfg_t   cfg;
  entry_t q_wdata, q_rdata;
  logic   q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  cbf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wdata)
  );

  cbf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  cbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_empty),
    .q_head_i     (q_rdata),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .is_check_o   (is_check_o),
    .status_o     (status_o),
    .end_of_run_o (end_of_run_o)
  );

  // A nonzero status only ever rides on the last result of a transaction
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> end_of_run_o)
    else $error("status set on a non-final result");

  // Check bytes always close a transaction
  a_check_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_check_o) |-> end_of_run_o)
    else $error("check byte not marked end of run");

  // A mismatch can only be reported on a check byte
  a_mismatch_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_MISMATCH) |-> is_check_o)
    else $error("mismatch reported on a data byte");

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("work queue overflow");

endmodule

### src/cbf_regs.sv
// ----------------------------------------------------------------------------
// cbf_regs
// APB-style register file holding polynomial, init value and output XOR.
// ----------------------------------------------------------------------------
module cbf_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cbf_pkg::AddrW-1:0] paddr,
  input  logic [cbf_pkg::DataW-1:0] pwdata,
  output logic [cbf_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output cbf_pkg::cfg_t             cfg_o
);
  import cbf_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_POLY:    cfg_d.poly    = pwdata[7:0];
        REG_INIT:    cfg_d.init    = pwdata[7:0];
        REG_XOR_OUT: cfg_d.xor_out = pwdata[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly    <= PolyRst;
      cfg_q.init    <= InitRst;
      cfg_q.xor_out <= XorOutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (sel)
      REG_POLY:    prdata = {{(DataW-8){1'b0}}, cfg_q.poly};
      REG_INIT:    prdata = {{(DataW-8){1'b0}}, cfg_q.init};
      REG_XOR_OUT: prdata = {{(DataW-8){1'b0}}, cfg_q.xor_out};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/cbf_front.sv
// ----------------------------------------------------------------------------
// cbf_front
// Accepts bytes, tracks group position and running CRC, classifies work.
// ----------------------------------------------------------------------------
module cbf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbf_pkg::cfg_t   cfg_i,
  input  logic            push_i,
  input  logic            action_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output cbf_pkg::entry_t q_entry_o
);
  import cbf_pkg::*;

  logic [7:0]      crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      crc_upd;
  logic [PosW-1:0] pos_inc;

  assign q_push_o = push_i & ~q_full_i;
  assign crc_upd  = crc8_update(crc_q, data_byte_i, cfg_i.poly);
  assign pos_inc  = pos_q + PosW'(1);

  // Classify the byte and advance the group state
  always_comb begin
    crc_d            = crc_q;
    pos_d            = pos_q;
    q_entry_o.data   = data_byte_i;
    q_entry_o.crc    = crc_upd;
    q_entry_o.pos    = pos_inc;
    q_entry_o.status = ST_OK;
    q_entry_o.op     = OP_ENC_DATA;
    if (!action_i) begin
      if (pos_inc >= GroupEnd) begin
        q_entry_o.op = OP_ENC_CHECK;
        crc_d        = cfg_i.init;
        pos_d        = '0;
      end else if (last_byte_i) begin
        q_entry_o.op = OP_ENC_PAD;
        crc_d        = cfg_i.init;
        pos_d        = '0;
      end else begin
        crc_d = crc_upd;
        pos_d = pos_inc;
      end
    end else begin
      if (pos_q >= GroupEnd) begin
        q_entry_o.op     = OP_DEC_CHECK;
        q_entry_o.status = ((crc_q ^ cfg_i.xor_out) != data_byte_i) ? ST_MISMATCH : ST_OK;
        crc_d            = cfg_i.init;
        pos_d            = '0;
      end else begin
        q_entry_o.op = OP_DEC_DATA;
        if (last_byte_i) begin
          q_entry_o.status = ST_BAD_LEN;
          crc_d            = cfg_i.init;
          pos_d            = '0;
        end else begin
          crc_d = crc_upd;
          pos_d = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= InitRst;
      pos_q <= '0;
    end else if (q_push_o) begin
      crc_q <= crc_d;
      pos_q <= pos_d;
    end
  end

endmodule

### src/cbf_fifo.sv
// ----------------------------------------------------------------------------
// cbf_fifo
// Short work queue between front and back.
// ----------------------------------------------------------------------------
module cbf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbf_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output cbf_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import cbf_pkg::*;

  entry_t            mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;

  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FifoAw+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FifoAw+1)'(1);
      end
    end
  end

endmodule

### src/cbf_back.sv
// ----------------------------------------------------------------------------
// cbf_back
// Expands queued work into result bytes: data, zero pads and check bytes.
// ----------------------------------------------------------------------------
module cbf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbf_pkg::cfg_t   cfg_i,
  input  logic            q_empty_i,
  input  cbf_pkg::entry_t q_head_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            is_check_o,
  output logic [1:0]      status_o,
  output logic            end_of_run_o
);
  import cbf_pkg::*;

  phase_e          phase_q, phase_d;
  logic [7:0]      crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q;
  logic [7:0]      out_byte_q, res_byte;
  logic            is_check_q, res_check;
  logic [1:0]      status_q, res_status;
  logic            end_q, res_end;
  logic            take, adv;

  // Output slot can load when empty or being drained this cycle
  assign take = ~out_valid_q | pop;
  assign adv  = take & ~q_empty_i;

  // Sequencer: next phase and the result for this phase
  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    pos_d      = pos_q;
    q_pop_o    = 1'b0;
    res_byte   = q_head_i.data;
    res_check  = 1'b0;
    res_status = ST_OK;
    res_end    = 1'b1;
    case (phase_q)
      PH_HEAD: begin
        res_check  = (q_head_i.op == OP_DEC_CHECK);
        res_status = q_head_i.status;
        res_end    = (q_head_i.op != OP_ENC_CHECK) && (q_head_i.op != OP_ENC_PAD);
        if (adv) begin
          crc_d = q_head_i.crc;
          pos_d = q_head_i.pos;
          if (q_head_i.op == OP_ENC_CHECK) begin
            phase_d = PH_CRC;
          end else if (q_head_i.op == OP_ENC_PAD) begin
            phase_d = PH_PAD;
          end else begin
            q_pop_o = 1'b1;
          end
        end
      end
      PH_PAD: begin
        res_byte = 8'h00;
        res_end  = 1'b0;
        if (adv) begin
          crc_d = crc8_update(crc_q, 8'h00, cfg_i.poly);
          pos_d = pos_q + PosW'(1);
          if (pos_d >= GroupEnd) begin
            phase_d = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        res_byte  = crc_q ^ cfg_i.xor_out;
        res_check = 1'b1;
        if (adv) begin
          q_pop_o = 1'b1;
          phase_d = PH_HEAD;
        end
      end
      default: begin
        phase_d = PH_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      crc_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      pos_q   <= pos_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= ~q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= res_byte;
      is_check_q <= res_check;
      status_q   <= res_status;
      end_q      <= res_end;
    end
  end

  assign empty        = ~out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_check_o   = is_check_q;
  assign status_o     = status_q;
  assign end_of_run_o = end_q;

endmodule
